// File: design/pcbp_pkg.sv
package pcbp_pkg;

  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned NUM_SYMBOLS  = 256;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned SYM_W        = 8;
  localparam int unsigned ADDR_W       = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WORK_W       = CODE_W + BYTE_W;
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic              flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

// File: design/prefix_code_bit_packer_top.sv
// With the block idle, a byte completed by an encode or flush request reaches the output
// through the queue, the packer and the output register; the table is read at acceptance.
// Throughput: one request per cycle while each completes at most one byte and the output
// is not stalled; a request that completes k bytes holds the packer until all k have left,
// since it emits one byte per cycle while the output accepts them.
// Reset clears all code lengths at once through per-entry valid flags, empties the queue
// and the partial byte; requests are accepted right after reset.
module prefix_code_bit_packer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [pcbp_pkg::SYM_W-1:0]  symbol_i,
  input  logic [pcbp_pkg::CODE_W-1:0] code_bits_i,
  input  logic [pcbp_pkg::LEN_W-1:0]  code_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pcbp_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        last_o
);

  logic             push, full, pop, empty;
  pcbp_pkg::entry_t push_data, pop_data;

  pcbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  pcbp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  pcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

// File: design/pcbp_front.sv
module pcbp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [pcbp_pkg::SYM_W-1:0]   symbol_i,
  input  logic [pcbp_pkg::CODE_W-1:0]  code_bits_i,
  input  logic [pcbp_pkg::LEN_W-1:0]   code_length_i,
  output logic                         push_o,
  output pcbp_pkg::entry_t             push_data_o,
  input  logic                         full_i
);

  logic [pcbp_pkg::CODE_W-1:0] code_mem [pcbp_pkg::NUM_SYMBOLS];
  logic [pcbp_pkg::LEN_W-1:0]  len_mem  [pcbp_pkg::NUM_SYMBOLS];
  logic [pcbp_pkg::NUM_SYMBOLS-1:0] len_vld_q;

  logic                        s1_valid_q, s1_valid_d;
  logic                        s1_flush_q;
  logic [pcbp_pkg::CODE_W-1:0] rd_code_q;
  logic [pcbp_pkg::LEN_W-1:0]  rd_len_q;
  logic                        rd_lv_q;

  logic                        accept;
  logic                        in_range;
  logic                        do_load;
  logic                        do_enq;
  logic                        is_flush;
  logic [pcbp_pkg::ADDR_W-1:0] addr;
  logic [pcbp_pkg::LEN_W-1:0]  len_clamped;

  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign addr       = symbol_i[pcbp_pkg::ADDR_W-1:0];
  assign in_range   = {1'b0, symbol_i} < (pcbp_pkg::SYM_W + 1)'(pcbp_pkg::NUM_SYMBOLS);
  assign is_flush   = operation_i == pcbp_pkg::OP_FLUSH;
  assign do_load    = accept && operation_i == pcbp_pkg::OP_LOAD && in_range;
  assign do_enq     = accept && (is_flush || (operation_i == pcbp_pkg::OP_ENCODE && in_range));
  assign push_o     = s1_valid_q && !full_i;

  assign len_clamped = (code_length_i > pcbp_pkg::LEN_W'(pcbp_pkg::LEN_LIMIT))
                     ? pcbp_pkg::LEN_W'(pcbp_pkg::LEN_LIMIT) : code_length_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (do_enq) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      len_vld_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (do_load) begin
        len_vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      code_mem[addr] <= code_bits_i;
      len_mem[addr]  <= len_clamped;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      s1_flush_q <= is_flush;
      rd_code_q  <= code_mem[addr];
      rd_len_q   <= len_mem[addr];
      rd_lv_q    <= len_vld_q[addr];
    end
  end

  always_comb begin
    push_data_o.flush = s1_flush_q;
    push_data_o.code  = rd_code_q;
    push_data_o.len   = (rd_lv_q && !s1_flush_q) ? rd_len_q : '0;
  end

endmodule

// File: design/pcbp_fifo.sv
module pcbp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcbp_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output pcbp_pkg::entry_t pop_data_o
);

  pcbp_pkg::entry_t mem_q [pcbp_pkg::FIFO_DEPTH];

  logic [pcbp_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [pcbp_pkg::FIFO_CW-1:0] count_q, count_d;
  logic                         do_push, do_pop;

  assign full_o     = count_q == pcbp_pkg::FIFO_CW'(pcbp_pkg::FIFO_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + pcbp_pkg::FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - pcbp_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == pcbp_pkg::FIFO_AW'(pcbp_pkg::FIFO_DEPTH - 1))
                  ? '0 : wr_ptr_q + pcbp_pkg::FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == pcbp_pkg::FIFO_AW'(pcbp_pkg::FIFO_DEPTH - 1))
                  ? '0 : rd_ptr_q + pcbp_pkg::FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/pcbp_back.sv
module pcbp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  pcbp_pkg::entry_t            pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pcbp_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        last_o
);

  logic [pcbp_pkg::WORK_W-1:0] work_q, work_d;
  logic [pcbp_pkg::LEN_W-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [pcbp_pkg::BYTE_W-1:0] out_byte_q;
  logic                        last_q;

  logic                        busy, out_free, emit;
  logic [pcbp_pkg::WORK_W-1:0] base_work, ext, aligned;
  logic [pcbp_pkg::LEN_W-1:0]  base_cnt, shamt;

  // Bits wait left aligned in the work register; whole bytes leave from the top.
  assign busy     = cnt_q >= pcbp_pkg::LEN_W'(pcbp_pkg::BYTE_W);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = busy && out_free;

  assign base_work = emit ? (work_q << pcbp_pkg::BYTE_W) : work_q;
  assign base_cnt  = emit ? (cnt_q - pcbp_pkg::LEN_W'(pcbp_pkg::BYTE_W)) : cnt_q;
  assign pop_o     = !empty_i && (base_cnt < pcbp_pkg::LEN_W'(pcbp_pkg::BYTE_W));

  assign ext     = {pop_data_i.code, {pcbp_pkg::BYTE_W{1'b0}}};
  assign shamt   = pcbp_pkg::LEN_W'(pcbp_pkg::CODE_W) - pop_data_i.len;
  assign aligned = (pop_data_i.len == '0) ? '0 : (ext << shamt);

  always_comb begin
    work_d = base_work;
    cnt_d  = base_cnt;
    if (pop_o) begin
      if (pop_data_i.flush) begin
        cnt_d = (base_cnt != '0) ? pcbp_pkg::LEN_W'(pcbp_pkg::BYTE_W) : '0;
      end else begin
        work_d = base_work | (aligned >> base_cnt);
        cnt_d  = base_cnt + pop_data_i.len;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_q      <= work_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= work_q[pcbp_pkg::WORK_W-1 -: pcbp_pkg::BYTE_W];
      last_q     <= cnt_q < pcbp_pkg::LEN_W'(2 * pcbp_pkg::BYTE_W);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule
